/* rtl/core/nctc_pkg.sv */
// Package for the nearest color tile classifier.
// Holds widths, register indexes, reset centroids, tile class codes and pipeline control types.
// No dependencies.
`default_nettype none

package nctc_pkg;

    localparam int CH_W          = 16;
    localparam int SQ_W          = 2 * CH_W;
    localparam int DIST_W        = SQ_W + 2;
    localparam int CFG_W         = 3 * CH_W;
    localparam int CFG_IDX_W     = 3;
    localparam int NUM_CENTROIDS = 5;

    typedef logic [CH_W-1:0]   chan_t;
    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [CFG_W-1:0]  centroid_t;

    localparam logic [CFG_IDX_W-1:0] IDX_VICTIM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_BLACK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_WHITE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_GRAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_BLUE   = 3'd4;

    localparam centroid_t RESET_VICTIM = {16'd21, 16'd32, 16'd94};
    localparam centroid_t RESET_BLACK  = {16'd7, 16'd12, 16'd18};
    localparam centroid_t RESET_WHITE  = {16'd107, 16'd182, 16'd193};
    localparam centroid_t RESET_GRAY   = {16'd61, 16'd105, 16'd136};
    localparam centroid_t RESET_BLUE   = '0;

    typedef enum logic [1:0] {
        CLASS_NORMAL = 2'd0,
        CLASS_VICTIM = 2'd1,
        CLASS_BLACK  = 2'd2,
        CLASS_BLUE   = 2'd3
    } tile_class_t;

    typedef struct packed {
        logic en_sq;
        logic en_sum;
        logic en_out;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/nctc_sqdist.sv */
// Squared distance from the registered sample to one centroid, over two pipeline stages.
// Per-channel absolute difference and square, then the sum of the three squares.
// Depends on nctc_pkg.
`default_nettype none

module nctc_sqdist
    import nctc_pkg::*;
(
    input  wire        clk,
    input  pipe_ctrl_t ctrl,
    input  chan_t      red,
    input  chan_t      green,
    input  chan_t      blue,
    input  centroid_t  centroid,
    output dist_t      dist_sq
);

    chan_t diff [3];
    chan_t samp [3];
    chan_t cent [3];
    sq_t   sq_reg [3];
    dist_t sum_reg;

    assign samp[0] = red;
    assign samp[1] = green;
    assign samp[2] = blue;
    assign cent[0] = centroid[CH_W-1:0];
    assign cent[1] = centroid[2*CH_W-1:CH_W];
    assign cent[2] = centroid[3*CH_W-1:2*CH_W];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = (samp[i] >= cent[i]) ? (samp[i] - cent[i]) : (cent[i] - samp[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_sq)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= sq_t'(diff[i]) * sq_t'(diff[i]);
            end
        end
        if (ctrl.en_sum)
        begin
            sum_reg <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
        end
    end

    assign dist_sq = sum_reg;

endmodule

`default_nettype wire

/* rtl/core/nctc_select.sv */
// Nearest centroid selection with the tie precedence victim, black, blue, then normal.
// Registers the tile class into the output stage.
// Depends on nctc_pkg.
`default_nettype none

module nctc_select
    import nctc_pkg::*;
(
    input  wire         clk,
    input  pipe_ctrl_t  ctrl,
    input  dist_t       dist_sq [NUM_CENTROIDS],
    output tile_class_t tile_class
);

    dist_t       dv;
    dist_t       dk;
    dist_t       dw;
    dist_t       dg;
    dist_t       db;
    logic        is_victim;
    logic        is_black;
    logic        is_blue;
    tile_class_t class_next;
    tile_class_t class_reg;

    assign dv = dist_sq[IDX_VICTIM];
    assign dk = dist_sq[IDX_BLACK];
    assign dw = dist_sq[IDX_WHITE];
    assign dg = dist_sq[IDX_GRAY];
    assign db = dist_sq[IDX_BLUE];

    assign is_victim = (dv <= dk) && (dv <= dw) && (dv <= dg) && (dv <= db);
    assign is_black  = (dk < dv) && (dk <= dw) && (dk <= dg) && (dk <= db);
    assign is_blue   = (db < dv) && (db < dk) && (db <= dw) && (db <= dg);

    always_comb
    begin
        if (is_victim)
        begin
            class_next = CLASS_VICTIM;
        end
        else if (is_black)
        begin
            class_next = CLASS_BLACK;
        end
        else if (is_blue)
        begin
            class_next = CLASS_BLUE;
        end
        else
        begin
            class_next = CLASS_NORMAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_out)
        begin
            class_reg <= class_next;
        end
    end

    assign tile_class = class_reg;

endmodule

`default_nettype wire

/* rtl/core/nearest_color_tile_classifier.sv */
// Nearest color tile classifier: input register, square, sum and select stages.
// Each accepted transaction passes the input, square and sum registers into the output register.
// Throughput is one transaction per cycle; each stage holds only while the one after it is full.
// Reset clears all stage valid flags and loads the five centroids with their default colors.
// Depends on nctc_pkg, nctc_sqdist and nctc_select.
`default_nettype none

module nearest_color_tile_classifier
    import nctc_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [47:0]          s_tdata,   // red_count, green_count, blue_count
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [7:0]           m_tdata,   // tile_class, zero fill
    input  wire                  cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0] cfg_index,
    input  wire  [CFG_W-1:0]     cfg_data
);

    centroid_t   centroid_reg [NUM_CENTROIDS];
    chan_t       red_reg;
    chan_t       green_reg;
    chan_t       blue_reg;
    logic        in_valid_reg;
    logic        sq_valid_reg;
    logic        sum_valid_reg;
    logic        out_valid_reg;
    logic        en_in;
    pipe_ctrl_t  ctrl;
    dist_t       dist_sq [NUM_CENTROIDS];
    tile_class_t tile_class;

    assign ctrl.en_out = !out_valid_reg || m_tready;
    assign ctrl.en_sum = !sum_valid_reg || ctrl.en_out;
    assign ctrl.en_sq  = !sq_valid_reg || ctrl.en_sum;
    assign en_in       = !in_valid_reg || ctrl.en_sq;
    assign s_tready    = en_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_in)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (ctrl.en_sq)
            begin
                sq_valid_reg <= in_valid_reg;
            end
            if (ctrl.en_sum)
            begin
                sum_valid_reg <= sq_valid_reg;
            end
            if (ctrl.en_out)
            begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_in)
        begin
            red_reg   <= s_tdata[CH_W-1:0];
            green_reg <= s_tdata[2*CH_W-1:CH_W];
            blue_reg  <= s_tdata[3*CH_W-1:2*CH_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centroid_reg[IDX_VICTIM] <= RESET_VICTIM;
            centroid_reg[IDX_BLACK]  <= RESET_BLACK;
            centroid_reg[IDX_WHITE]  <= RESET_WHITE;
            centroid_reg[IDX_GRAY]   <= RESET_GRAY;
            centroid_reg[IDX_BLUE]   <= RESET_BLUE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                IDX_VICTIM: centroid_reg[IDX_VICTIM] <= cfg_data;
                IDX_BLACK:  centroid_reg[IDX_BLACK]  <= cfg_data;
                IDX_WHITE:  centroid_reg[IDX_WHITE]  <= cfg_data;
                IDX_GRAY:   centroid_reg[IDX_GRAY]   <= cfg_data;
                IDX_BLUE:   centroid_reg[IDX_BLUE]   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    for (genvar i = 0; i < NUM_CENTROIDS; i++)
    begin : g_dist
        nctc_sqdist u_sqdist (
            .clk      (clk),
            .ctrl     (ctrl),
            .red      (red_reg),
            .green    (green_reg),
            .blue     (blue_reg),
            .centroid (centroid_reg[i]),
            .dist_sq  (dist_sq[i])
        );
    end

    nctc_select u_select (
        .clk        (clk),
        .ctrl       (ctrl),
        .dist_sq    (dist_sq),
        .tile_class (tile_class)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, tile_class};

endmodule

`default_nettype wire
